// ===== rtl/vots_pkg.sv =====
// Types, constants and the reciprocal table shared by the run queue files.
`default_nettype none
package vots_pkg;

   localparam int ID_W    = 8;
   localparam int VRUN_W  = 63;
   localparam int PRIO_W  = 2;
   localparam int CNT_W   = 5;
   localparam int SLICE_W = 10;
   localparam int BASE_W  = 8;
   localparam int RECIP_W = 17;
   localparam int REQ_W   = 144;
   localparam int RSP_W   = 88;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_SCHEDULE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TASK_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PRIORITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_BASE    = 2'd2;

   localparam logic [CNT_W-1:0]   COUNT_MAX        = 5'd31;
   localparam logic [CNT_W-1:0]   COUNT_RESET      = 5'd1;
   localparam logic [SLICE_W-1:0] SLICE_RESET      = 10'd4;
   localparam logic [BASE_W-1:0]  SLICE_BASE_RESET = 8'd4;

   localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd2;
   localparam logic [PRIO_W-1:0] PRIO_TOP  = 2'd3;

   // ceil(2^16 / count); a count of zero divides as one
   localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
      17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923, 17'd9363,
      17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,  17'd4682,  17'd4370,
      17'd4096,  17'd3856,  17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850,
      17'd2731,  17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,  17'd2185,  17'd2115
   };

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [VRUN_W-1:0] vrun;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic pop;
      logic cmp;
      logic ins;
   } cell_ctl_type;

   typedef struct packed {
      logic valid;
      logic le;
      logic hit;
   } cell_stat_type;

endpackage
`default_nettype wire

// ===== rtl/vots_cell.sv =====
// One slot of the sorted run queue: holds an entry and trades it with its neighbors.
`default_nettype none
module vots_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  vots_pkg::cell_ctl_type  ctl,
   input  vots_pkg::entry_type     key,
   input  vots_pkg::entry_type     left_entry,
   input  logic                    left_valid,
   input  logic                    left_le,
   input  vots_pkg::entry_type     right_entry,
   input  logic                    right_valid,
   output vots_pkg::entry_type     entry,
   output vots_pkg::cell_stat_type stat
);
   import vots_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      le_ff, le_in;
   logic      hit_ff, hit_in;
   logic      le_now;

   always_comb begin
      le_now   = valid_ff && (entry_ff.vrun <= key.vrun);
      entry_in = entry_ff;
      valid_in = valid_ff;
      le_in    = le_ff;
      hit_in   = hit_ff;
      if (ctl.cmp) begin
         le_in  = le_now;
         hit_in = le_now && (entry_ff.id == key.id);
      end
      if (ctl.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (ctl.ins) begin
         // the slot right after the last entry at or below the key takes it
         if (left_le && !le_ff) begin
            entry_in = key;
            valid_in = 1'b1;
         end else if (!left_le && left_valid) begin
            entry_in = left_entry;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      le_ff    <= le_in;
      hit_ff   <= hit_in;
   end

   assign entry      = entry_ff;
   assign stat.valid = valid_ff;
   assign stat.le    = le_ff;
   assign stat.hit   = hit_ff;

endmodule
`default_nettype wire

// ===== rtl/vruntime_ordered_task_scheduler.sv =====
// Run queue sorted by virtual run time, with schedule decision and time slice.
//
// A chain of QUEUE_DEPTH cells keeps the queued tasks in ascending order of
// virtual run time; each cell compares its entry with a broadcast key and
// shifts toward its neighbor on an insert or a pop. One item is worked at a
// time: an insert item goes from acceptance to a loaded result through accept,
// compare in all cells, shift-in and slice; a schedule item adds a pop step
// that pops the head and makes the switch decision. The slice divide uses a
// 32-entry reciprocal table and one 8x17 multiply. The next item is accepted
// while a finished result still waits in the output register; the block holds
// in its slice step only if that register is full.
`default_nettype none
module vruntime_ordered_task_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [vots_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vots_pkg::BASE_W-1:0]       csr_wdata,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // task_id[7:0], run_time[70:8], task_priority[72:71], task_running[73],
   // idle_run_time[136:74], zero pad[143:137]
   input  logic [vots_pkg::REQ_W-1:0]        req_tdata,
   // operation[0]
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_task_id[7:0], do_switch[8], slice_ticks[18:9], min_vrun[81:19],
   // queued_count[86:82], queue_full[87]
   output logic [vots_pkg::RSP_W-1:0]        rsp_tdata
);
   import vots_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_POP   = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_APPLY = 3'd3;
   localparam logic [2:0] ST_SLICE = 3'd4;

   localparam logic [1:0] SM_NONE   = 2'd0;
   localparam logic [1:0] SM_SWITCH = 2'd1;
   localparam logic [1:0] SM_KEEP   = 2'd2;

   // control
   logic [2:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic [VRUN_W-1:0]  minv_ff, minv_in;
   logic [ID_W-1:0]    idle_id_ff, idle_id_in;
   logic [PRIO_W-1:0]  idle_prio_ff, idle_prio_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic               ins_en_ff, ins_en_in;
   logic [1:0]         smode_ff, smode_in;

   // payload
   logic [ID_W-1:0]    id_ff, id_in;
   logic [VRUN_W-1:0]  vrun_ff, vrun_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic               running_ff, running_in;
   logic [VRUN_W-1:0]  idle_vrun_ff, idle_vrun_in;
   entry_type          key_ff, key_in;
   logic [PRIO_W-1:0]  sprio_ff, sprio_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic               sw_ff, sw_in;
   logic               full_ff, full_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // cell chain
   cell_ctl_type              ctl;
   entry_type                 ents [QUEUE_DEPTH];
   cell_stat_type             stats [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]    valid_vec;
   logic [QUEUE_DEPTH-1:0]    hit_vec;

   // working signals
   logic               accept;
   logic               head_valid;
   entry_type          head;
   entry_type          nxt;
   logic               sw_path;
   logic               dup;
   logic               is_idle;
   logic               full_now;
   logic               ins_go;
   logic [RECIP_W-1:0] recip;
   logic [24:0]        prod;
   logic [BASE_W-1:0]  share;
   logic [SLICE_W-1:0] share3;
   logic [SLICE_W-1:0] slice_new;
   logic               load;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         entry_type left_entry;
         logic      left_valid;
         logic      left_le;
         entry_type right_entry;
         logic      right_valid;
         if (gi == 0) begin : g_first
            assign left_entry = key_ff;
            assign left_valid = 1'b0;
            assign left_le    = 1'b1;
         end else begin : g_mid
            assign left_entry = ents[gi-1];
            assign left_valid = stats[gi-1].valid;
            assign left_le    = stats[gi-1].le;
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = key_ff;
            assign right_valid = 1'b0;
         end else begin : g_inner
            assign right_entry = ents[gi+1];
            assign right_valid = stats[gi+1].valid;
         end
         vots_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .key         (key_ff),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .left_le     (left_le),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .entry       (ents[gi]),
            .stat        (stats[gi])
         );
         assign valid_vec[gi] = stats[gi].valid;
         assign hit_vec[gi]   = stats[gi].hit;
      end
   endgenerate

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign head_valid = valid_vec[0];
   assign head       = ents[0];

   assign dup      = |hit_vec;
   assign full_now = valid_vec[QUEUE_DEPTH-1];
   assign is_idle  = (key_ff.id == idle_id_ff);
   assign ins_go   = (state_ff == ST_APPLY) && ins_en_ff && !is_idle && !dup && !full_now;

   // slice share = slice_base / max(count, 1)
   assign recip  = RECIP_TABLE[count_ff];
   assign prod   = 25'(base_ff) * 25'(recip);
   assign share  = prod[23:16];
   assign share3 = {2'b00, share} + {1'b0, share, 1'b0};
   assign load   = (state_ff == ST_SLICE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      case (smode_ff)
         SM_SWITCH: begin
            if (sprio_ff == PRIO_TOP) begin
               slice_new = '0;
            end else if (sprio_ff == PRIO_HIGH) begin
               slice_new = share3;
            end else begin
               slice_new = {2'b00, share};
            end
         end
         SM_KEEP: begin
            if (slice_ff != '0) begin
               slice_new = slice_ff;
            end else if (sprio_ff[1]) begin
               slice_new = share3;
            end else begin
               slice_new = {2'b00, share};
            end
         end
         default: slice_new = slice_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      slice_in     = slice_ff;
      minv_in      = minv_ff;
      idle_id_in   = idle_id_ff;
      idle_prio_in = idle_prio_ff;
      base_in      = base_ff;
      ins_en_in    = ins_en_ff;
      smode_in     = smode_ff;
      id_in        = id_ff;
      vrun_in      = vrun_ff;
      prio_in      = prio_ff;
      running_in   = running_ff;
      idle_vrun_in = idle_vrun_ff;
      key_in       = key_ff;
      sprio_in     = sprio_ff;
      next_id_in   = next_id_ff;
      sw_in        = sw_ff;
      full_in      = full_ff;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;
      nxt          = head;
      sw_path      = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_IDLE_TASK_ID:  idle_id_in   = csr_wdata;
            CSR_IDLE_PRIORITY: idle_prio_in = csr_wdata[PRIO_W-1:0];
            CSR_SLICE_BASE:    base_in      = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in        = req_tdata[7:0];
               vrun_in      = req_tdata[70:8];
               prio_in      = req_tdata[72:71];
               running_in   = req_tdata[73];
               idle_vrun_in = req_tdata[136:74];
               full_in      = 1'b0;
               next_id_in   = '0;
               sw_in        = 1'b0;
               smode_in     = SM_NONE;
               key_in.id    = req_tdata[7:0];
               key_in.vrun  = req_tdata[70:8];
               key_in.prio  = req_tdata[72:71];
               ins_en_in    = 1'b1;
               sprio_in     = req_tdata[72:71];
               state_in     = (req_tuser == OP_INSERT) ? ST_CMP : ST_POP;
            end
         end
         ST_POP: begin
            if (head_valid) begin
               ctl.pop = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               minv_in = (head.vrun < vrun_ff) ? head.vrun : vrun_ff;
            end else begin
               nxt.id   = idle_id_ff;
               nxt.vrun = idle_vrun_ff;
               nxt.prio = idle_prio_ff;
               minv_in  = vrun_ff;
            end
            sw_path  = (vrun_ff >= nxt.vrun) || !running_ff;
            sprio_in = nxt.prio;
            if (sw_path) begin
               if (nxt.id == id_ff) begin
                  // current task runs on; the popped copy is dropped
                  ins_en_in  = 1'b0;
                  smode_in   = SM_NONE;
                  next_id_in = id_ff;
                  sw_in      = 1'b0;
               end else begin
                  key_in.id   = id_ff;
                  key_in.vrun = vrun_ff;
                  key_in.prio = prio_ff;
                  ins_en_in   = running_ff;
                  smode_in    = SM_SWITCH;
                  next_id_in  = nxt.id;
                  sw_in       = 1'b1;
               end
            end else begin
               // keep the current task, requeue the popped one
               key_in     = nxt;
               ins_en_in  = 1'b1;
               smode_in   = SM_KEEP;
               next_id_in = id_ff;
               sw_in      = 1'b0;
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            ctl.cmp  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ctl.ins = ins_go;
            full_in = ins_en_ff && !is_idle && !dup && full_now;
            if (ins_go) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               if (key_ff.vrun < minv_ff) begin
                  minv_in = key_ff.vrun;
               end
            end
            state_in = ST_SLICE;
         end
         ST_SLICE: begin
            if (load) begin
               slice_in     = slice_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {full_ff, count_ff, minv_ff, slice_new, sw_ff, next_id_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
         slice_ff     <= SLICE_RESET;
         minv_ff      <= '0;
         idle_id_ff   <= '0;
         idle_prio_ff <= '0;
         base_ff      <= SLICE_BASE_RESET;
         ins_en_ff    <= 1'b0;
         smode_ff     <= SM_NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         slice_ff     <= slice_in;
         minv_ff      <= minv_in;
         idle_id_ff   <= idle_id_in;
         idle_prio_ff <= idle_prio_in;
         base_ff      <= base_in;
         ins_en_ff    <= ins_en_in;
         smode_ff     <= smode_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      vrun_ff      <= vrun_in;
      prio_ff      <= prio_in;
      running_ff   <= running_in;
      idle_vrun_ff <= idle_vrun_in;
      key_ff       <= key_in;
      sprio_ff     <= sprio_in;
      next_id_ff   <= next_id_in;
      sw_ff        <= sw_in;
      full_ff      <= full_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // occupied cells always form a run from the head
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
      else $error("queue cells not packed toward head");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ins_go |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("insert did not add exactly one entry");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && head_valid) |=>
         $countones(valid_vec) == $past($countones(valid_vec)) - 1)
      else $error("pop did not remove exactly one entry");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && ins_en_ff && !is_idle && !dup && !full_now) |=> !full_ff)
      else $error("queue_full raised with room left");

endmodule
`default_nettype wire
